[sv/polygon_plane_clipper_macros.svh]
// Assertion helpers shared by the clipper modules.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef POLYGON_PLANE_CLIPPER_MACROS_SVH
`define POLYGON_PLANE_CLIPPER_MACROS_SVH

// Same-cycle implication.
`define PCL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PCL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/pcl_pkg.sv]
`default_nettype none

package pcl_pkg;

    localparam int VTX_N     = 5;
    localparam int COORD_W   = 32;
    localparam int NRM_W     = 18;
    localparam int PD_W      = 32;
    localparam int DIST_W    = 48;
    localparam int PROD_W    = NRM_W + COORD_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int FRAC_W    = 24;
    localparam int REM_W     = DIST_W + 1;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int IPROD_W   = FRAC_W + 1 + DIFF_W;
    localparam int MAX_VERTS = 32;
    localparam int CNT_W     = $clog2(MAX_VERTS + 1);
    localparam int KEPT_W    = 6;
    localparam int VIDX_W    = $clog2(VTX_N);
    localparam int MUL_STEPS = VTX_N + 1;
    localparam int MULC_W    = $clog2(MUL_STEPS);
    localparam int DIV_STEPS = FRAC_W;
    localparam int SEQC_W    = $clog2(DIV_STEPS + 1);

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_DISTANCE = 2'd3;

    localparam logic [NRM_W-1:0] NORMAL_Z_RESET = NRM_W'(65536);

    localparam logic [1:0] EMIT_NONE  = 2'd0;
    localparam logic [1:0] EMIT_START = 2'd1;
    localparam logic [1:0] EMIT_MID   = 2'd2;
    localparam logic [1:0] EMIT_EMPTY = 2'd3;

    localparam logic EDGE_A = 1'b0;
    localparam logic EDGE_B = 1'b1;

    typedef struct packed {
        logic              take;
        logic              dist_en;
        logic [1:0]        dist_k;
        logic              dfin;
        logic              setfirst;
        logic [1:0]        emit;
        logic              eop;
        logic              sel;
        logic              div_init;
        logic              div_step;
        logic              mul_en;
        logic [MULC_W-1:0] mul_k;
        logic              done;
    } pcl_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic seen;
        logic final_v;
        logic a_keep;
        logic a_cross;
        logic b_keep;
        logic b_cross;
        logic out_free;
    } pcl_status_t;

endpackage

`default_nettype wire

[sv/pcl_vertex_if.sv]
`default_nettype none

interface pcl_vertex_if import pcl_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] tex_s;
    logic signed [COORD_W-1:0] tex_t;
    logic                      final_vertex;

    modport source (output valid, pos_x, pos_y, pos_z, tex_s, tex_t, final_vertex,
                    input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, tex_s, tex_t, final_vertex,
                  output ready);
endinterface

`default_nettype wire

[sv/pcl_result_if.sv]
`default_nettype none

interface pcl_result_if import pcl_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic signed [COORD_W-1:0] out_s;
    logic signed [COORD_W-1:0] out_t;
    logic                      end_of_polygon;
    logic [KEPT_W-1:0]         kept_count;
    logic                      nothing_kept;
    logic                      count_overflow;

    modport source (output valid, out_x, out_y, out_z, out_s, out_t, end_of_polygon,
                    kept_count, nothing_kept, count_overflow, input ready);
    modport sink (input valid, out_x, out_y, out_z, out_s, out_t, end_of_polygon,
                  kept_count, nothing_kept, count_overflow, output ready);
endinterface

`default_nettype wire

[sv/pcl_datapath.sv]
`default_nettype none

`include "polygon_plane_clipper_macros.svh"

module pcl_datapath import pcl_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire pcl_cmd_t             cmd,
    output pcl_status_t               status,
    pcl_vertex_if.sink                vertex,
    pcl_result_if.source              result
);

    logic signed [NRM_W-1:0]   nx_reg, ny_reg, nz_reg;
    logic signed [PD_W-1:0]    pd_reg;

    logic signed [COORD_W-1:0] cur_reg   [VTX_N];
    logic signed [COORD_W-1:0] first_reg [VTX_N];
    logic signed [COORD_W-1:0] prev_reg  [VTX_N];
    logic signed [COORD_W-1:0] mid_reg   [VTX_N];
    logic signed [COORD_W-1:0] outv_reg  [VTX_N];
    logic                      final_reg;

    logic signed [DIST_W-1:0]  d_reg, dfirst_reg, dprev_reg;
    logic                      seen_reg;

    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;

    logic [REM_W-1:0]          rem_reg, den_reg;
    logic [FRAC_W-1:0]         frac_reg;

    logic signed [IPROD_W-1:0] iprod_reg;
    logic signed [COORD_W-1:0] ahold_reg;

    logic [CNT_W-1:0]          count_reg;
    logic                      ovf_reg;

    logic                      out_valid_reg;
    logic                      eop_reg;
    logic [KEPT_W-1:0]         kept_reg;
    logic                      nothing_reg;
    logic                      ovfout_reg;

    // Edge selection.
    logic signed [COORD_W-1:0] a_vtx [VTX_N];
    logic signed [COORD_W-1:0] b_vtx [VTX_N];
    logic signed [DIST_W-1:0]  da, db;

    always_comb
    begin
        for (int i = 0; i < VTX_N; i++)
        begin
            a_vtx[i] = (cmd.sel == EDGE_A) ? prev_reg[i] : cur_reg[i];
            b_vtx[i] = (cmd.sel == EDGE_A) ? cur_reg[i]  : first_reg[i];
        end
        da = (cmd.sel == EDGE_A) ? dprev_reg : d_reg;
        db = (cmd.sel == EDGE_A) ? d_reg     : dfirst_reg;
    end

    function automatic logic crosses(input logic signed [DIST_W-1:0] x,
                                     input logic signed [DIST_W-1:0] y);
        return (x != '0) && (y != '0) && (x[DIST_W-1] != y[DIST_W-1]);
    endfunction

    logic out_free;
    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        status.in_valid = vertex.valid;
        status.seen     = seen_reg;
        status.final_v  = final_reg;
        status.a_keep   = seen_reg && !dprev_reg[DIST_W-1];
        status.a_cross  = seen_reg && crosses(dprev_reg, d_reg);
        status.b_keep   = final_reg && !d_reg[DIST_W-1];
        status.b_cross  = final_reg && crosses(d_reg, dfirst_reg);
        status.out_free = out_free;
    end

    assign vertex.ready = cmd.take;

    // Distance multiplier operand.
    logic signed [NRM_W-1:0]   nrm_sel;
    logic signed [COORD_W-1:0] crd_sel;

    always_comb
    begin
        unique case (cmd.dist_k)
            2'd0:
            begin
                nrm_sel = nx_reg;
                crd_sel = cur_reg[0];
            end
            2'd1:
            begin
                nrm_sel = ny_reg;
                crd_sel = cur_reg[1];
            end
            2'd2:
            begin
                nrm_sel = nz_reg;
                crd_sel = cur_reg[2];
            end
            default:
            begin
                nrm_sel = '0;
                crd_sel = '0;
            end
        endcase
    end

    // Divider and interpolation helpers.
    logic [REM_W-1:0]         num_abs, db_abs;
    logic [REM_W:0]           shifted;
    logic                     qbit;
    logic signed [DIFF_W-1:0] diff;
    logic [VIDX_W-1:0]        vk, vk_prev;
    logic signed [IPROD_W-1:0] rounded;

    always_comb
    begin
        num_abs = da[DIST_W-1] ? REM_W'(-da) : REM_W'(da);
        db_abs  = db[DIST_W-1] ? REM_W'(-db) : REM_W'(db);
        shifted = {rem_reg, 1'b0};
        qbit    = shifted >= {1'b0, den_reg};
        vk      = VIDX_W'(cmd.mul_k);
        vk_prev = VIDX_W'(cmd.mul_k - MULC_W'(1));
        diff    = DIFF_W'(b_vtx[vk]) - DIFF_W'(a_vtx[vk]);
        rounded = (iprod_reg + (IPROD_W'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
    end

    // Count update for a vertex-carrying result.
    logic [CNT_W-1:0] cnt_next;
    logic             ovf_next;

    always_comb
    begin
        if (count_reg >= CNT_W'(MAX_VERTS))
        begin
            cnt_next = count_reg;
            ovf_next = 1'b1;
        end
        else
        begin
            cnt_next = count_reg + CNT_W'(1);
            ovf_next = ovf_reg;
        end
    end

    // Configuration registers and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg        <= '0;
            ny_reg        <= '0;
            nz_reg        <= NORMAL_Z_RESET;
            pd_reg        <= '0;
            seen_reg      <= 1'b0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_NORMAL_X:       nx_reg <= NRM_W'(cfg_data);
                    REG_NORMAL_Y:       ny_reg <= NRM_W'(cfg_data);
                    REG_NORMAL_Z:       nz_reg <= NRM_W'(cfg_data);
                    REG_PLANE_DISTANCE: pd_reg <= PD_W'(cfg_data);
                    default:            ;
                endcase
            end

            if (cmd.emit != EMIT_NONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.emit == EMIT_START || cmd.emit == EMIT_MID)
            begin
                count_reg <= cnt_next;
                ovf_reg   <= ovf_next;
            end

            if (cmd.done)
            begin
                seen_reg <= !final_reg;
                if (final_reg)
                begin
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.take && vertex.valid)
        begin
            cur_reg[0] <= vertex.pos_x;
            cur_reg[1] <= vertex.pos_y;
            cur_reg[2] <= vertex.pos_z;
            cur_reg[3] <= vertex.tex_s;
            cur_reg[4] <= vertex.tex_t;
            final_reg  <= vertex.final_vertex;
        end

        if (cmd.dist_en)
        begin
            prod_reg <= PROD_W'(nrm_sel * crd_sel);
            if (cmd.dist_k == 2'd1)
            begin
                acc_reg <= ACC_W'(prod_reg);
            end
            else if (cmd.dist_k != 2'd0)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end

        if (cmd.dfin)
        begin
            d_reg <= DIST_W'(acc_reg >>> 16) - DIST_W'(pd_reg);
        end

        if (cmd.setfirst && !seen_reg)
        begin
            first_reg  <= cur_reg;
            dfirst_reg <= d_reg;
        end

        if (cmd.div_init)
        begin
            rem_reg  <= num_abs;
            den_reg  <= num_abs + db_abs;
            frac_reg <= '0;
        end

        if (cmd.div_step)
        begin
            rem_reg  <= qbit ? REM_W'(shifted - {1'b0, den_reg}) : REM_W'(shifted);
            frac_reg <= {frac_reg[FRAC_W-2:0], qbit};
        end

        if (cmd.mul_en)
        begin
            if (cmd.mul_k < MULC_W'(VTX_N))
            begin
                iprod_reg <= IPROD_W'($signed({1'b0, frac_reg}) * diff);
                ahold_reg <= a_vtx[vk];
            end
            if (cmd.mul_k != '0)
            begin
                mid_reg[vk_prev] <= ahold_reg + COORD_W'(rounded);
            end
        end

        if (cmd.done)
        begin
            prev_reg  <= cur_reg;
            dprev_reg <= d_reg;
        end

        unique case (cmd.emit)
            EMIT_START:
            begin
                outv_reg    <= a_vtx;
                eop_reg     <= cmd.eop;
                kept_reg    <= KEPT_W'(cnt_next);
                nothing_reg <= 1'b0;
                ovfout_reg  <= ovf_next;
            end
            EMIT_MID:
            begin
                outv_reg    <= mid_reg;
                eop_reg     <= cmd.eop;
                kept_reg    <= KEPT_W'(cnt_next);
                nothing_reg <= 1'b0;
                ovfout_reg  <= ovf_next;
            end
            EMIT_EMPTY:
            begin
                for (int i = 0; i < VTX_N; i++)
                begin
                    outv_reg[i] <= '0;
                end
                eop_reg     <= 1'b1;
                kept_reg    <= '0;
                nothing_reg <= 1'b1;
                ovfout_reg  <= 1'b0;
            end
            default: ;
        endcase
    end

    assign result.valid          = out_valid_reg;
    assign result.out_x          = outv_reg[0];
    assign result.out_y          = outv_reg[1];
    assign result.out_z          = outv_reg[2];
    assign result.out_s          = outv_reg[3];
    assign result.out_t          = outv_reg[4];
    assign result.end_of_polygon = eop_reg;
    assign result.kept_count     = kept_reg;
    assign result.nothing_kept   = nothing_reg;
    assign result.count_overflow = ovfout_reg;

    `PCL_ASSERT_NOW(a_emit_has_room, cmd.emit != EMIT_NONE, out_free, "beat overwritten before taken")
    `PCL_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_VERTS), "vertex count out of range")
    `PCL_ASSERT_NEXT(a_final_clears, cmd.done && final_reg, !seen_reg && count_reg == '0, "polygon state not cleared")

endmodule

`default_nettype wire

[sv/pcl_controller.sv]
`default_nettype none

`include "polygon_plane_clipper_macros.svh"

module pcl_controller import pcl_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire pcl_status_t status,
    output pcl_cmd_t         cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_M0    = 4'd1;
    localparam logic [3:0] S_M1    = 4'd2;
    localparam logic [3:0] S_M2    = 4'd3;
    localparam logic [3:0] S_M3    = 4'd4;
    localparam logic [3:0] S_DF    = 4'd5;
    localparam logic [3:0] S_SF    = 4'd6;
    localparam logic [3:0] S_START = 4'd7;
    localparam logic [3:0] S_CROSS = 4'd8;
    localparam logic [3:0] S_DIVI  = 4'd9;
    localparam logic [3:0] S_DIV   = 4'd10;
    localparam logic [3:0] S_MUL   = 4'd11;
    localparam logic [3:0] S_MID   = 4'd12;
    localparam logic [3:0] S_FIN   = 4'd13;

    logic [3:0]        state_reg, state_next;
    logic              edge_reg, edge_next;
    logic [SEQC_W-1:0] cnt_reg, cnt_next;

    logic keep, cross_now, eop_start, eop_mid, empty;
    logic [3:0] after_state;
    logic       after_edge;

    always_comb
    begin
        keep      = (edge_reg == EDGE_A) ? status.a_keep  : status.b_keep;
        cross_now = (edge_reg == EDGE_A) ? status.a_cross : status.b_cross;
        eop_start = (edge_reg == EDGE_A)
                  ? (status.final_v && !status.a_cross && !status.b_keep && !status.b_cross)
                  : !status.b_cross;
        eop_mid   = (edge_reg == EDGE_A)
                  ? (status.final_v && !status.b_keep && !status.b_cross)
                  : 1'b1;
        empty = status.final_v && !status.a_keep && !status.a_cross
                && !status.b_keep && !status.b_cross;
        if (edge_reg == EDGE_A && status.final_v)
        begin
            after_state = S_START;
            after_edge  = EDGE_B;
        end
        else
        begin
            after_state = S_FIN;
            after_edge  = edge_reg;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.sel    = edge_reg;
        state_next = state_reg;
        edge_next  = edge_reg;
        cnt_next   = cnt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd.take = 1'b1;
                if (status.in_valid)
                begin
                    state_next = S_M0;
                end
            end
            S_M0:
            begin
                cmd.dist_en = 1'b1;
                cmd.dist_k  = 2'd0;
                state_next  = S_M1;
            end
            S_M1:
            begin
                cmd.dist_en = 1'b1;
                cmd.dist_k  = 2'd1;
                state_next  = S_M2;
            end
            S_M2:
            begin
                cmd.dist_en = 1'b1;
                cmd.dist_k  = 2'd2;
                state_next  = S_M3;
            end
            S_M3:
            begin
                cmd.dist_en = 1'b1;
                cmd.dist_k  = 2'd3;
                state_next  = S_DF;
            end
            S_DF:
            begin
                cmd.dfin   = 1'b1;
                state_next = S_SF;
            end
            S_SF:
            begin
                cmd.setfirst = 1'b1;
                if (status.seen)
                begin
                    state_next = S_START;
                    edge_next  = EDGE_A;
                end
                else if (status.final_v)
                begin
                    state_next = S_START;
                    edge_next  = EDGE_B;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_START:
            begin
                if (!keep)
                begin
                    state_next = S_CROSS;
                end
                else if (status.out_free)
                begin
                    cmd.emit   = EMIT_START;
                    cmd.eop    = eop_start;
                    state_next = S_CROSS;
                end
            end
            S_CROSS:
            begin
                if (cross_now)
                begin
                    state_next = S_DIVI;
                end
                else
                begin
                    state_next = after_state;
                    edge_next  = after_edge;
                end
            end
            S_DIVI:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == SEQC_W'(DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg + SEQC_W'(1);
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_k  = MULC_W'(cnt_reg);
                if (cnt_reg == SEQC_W'(MUL_STEPS - 1))
                begin
                    state_next = S_MID;
                end
                else
                begin
                    cnt_next = cnt_reg + SEQC_W'(1);
                end
            end
            S_MID:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = EMIT_MID;
                    cmd.eop    = eop_mid;
                    state_next = after_state;
                    edge_next  = after_edge;
                end
            end
            S_FIN:
            begin
                if (!empty)
                begin
                    cmd.done   = 1'b1;
                    state_next = S_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.emit   = EMIT_EMPTY;
                    cmd.done   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            edge_reg  <= EDGE_A;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            edge_reg  <= edge_next;
            cnt_reg   <= cnt_next;
        end
    end

    `PCL_ASSERT_NEXT(a_accept_starts, state_reg == S_IDLE && status.in_valid, state_reg == S_M0, "accepted vertex not started")
    `PCL_ASSERT_NOW(a_edge_b_final, state_reg == S_START && edge_reg == EDGE_B, status.final_v, "wrap edge on non-final vertex")
    `PCL_ASSERT_NOW(a_state_legal, 1'b1, state_reg <= S_FIN, "illegal controller state")

endmodule

`default_nettype wire

[sv/polygon_plane_clipper.sv]
// Clips a convex polygon against one plane, one vertex beat in and zero to four
// result beats out per vertex; a vertex is fully walked before the next is
// accepted. The first vertex of a longer polygon has no edge yet, and the final
// vertex of a polygon with two or more vertices also walks the wrap edge. Each
// edge that crosses the plane adds a setup step, a 24-step restoring divider
// for the crossing fraction, a shared multiplier for the five components and an
// emit step; a busy result sink adds stalls. The user must write the plane
// registers through cfg_we / cfg_index / cfg_data only while the block is idle;
// the block itself does not enforce this.
`default_nettype none

module polygon_plane_clipper import pcl_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    pcl_vertex_if.sink                vertex,
    pcl_result_if.source              result
);

    // The controller sequences distance, divide, interpolate and emit steps;
    // the datapath owns every arithmetic unit and the result register.
    pcl_cmd_t    cmd;
    pcl_status_t status;

    pcl_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    pcl_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .vertex    (vertex),
        .result    (result)
    );

endmodule

`default_nettype wire

[tb/sv/polygon_plane_clipper_tb.sv]
`default_nettype none

module polygon_plane_clipper_tb;
    import pcl_pkg::*;

    // One clipped-polygon result beat as the block should produce it.
    typedef struct {
        logic signed [COORD_W-1:0] x, y, z, s, t;
        logic                      eop;
        logic [KEPT_W-1:0]         kept;
        logic                      empty;
        logic                      ovf;
    } clip_beat_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIST_W-1:0]  dist_t;

    logic clk;
    logic rst_n;
    logic             cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    pcl_vertex_if vtx_ch ();
    pcl_result_if res_ch ();

    polygon_plane_clipper i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .vertex    (vtx_ch.sink),
        .result    (res_ch.source)
    );

    // Predictor copy of the plane registers.
    logic signed [NRM_W-1:0] pl_nx, pl_ny, pl_nz;
    logic signed [PD_W-1:0]  pl_d;

    // Predictor copy of the polygon walking state.
    coord_t      first_v [VTX_N];
    coord_t      prev_v  [VTX_N];
    longint      first_dist, prev_dist;
    bit          have_vertex;
    int          emit_count;
    bit          ovf_sticky;

    clip_beat_t  expected_beats[$];

    int          send_idle_pct;
    int          recv_stall_pct;
    int          error_count;
    int          beats_checked;
    int          vertices_sent;
    int          polygons_sent;
    longint      cycle_count;

    localparam longint CYCLE_LIMIT = 2_000_000;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: the slowest correct run is far below this limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic longint floor_shr(longint v, int sh);
        // Arithmetic shift on a signed longint is a floor divide by 2^sh.
        return v >>> sh;
    endfunction

    function automatic clip_beat_t make_beat(coord_t v [VTX_N]);
        clip_beat_t b;
        if (emit_count >= MAX_VERTS)
            ovf_sticky = 1'b1;
        else
            emit_count++;
        b.x = v[0]; b.y = v[1]; b.z = v[2]; b.s = v[3]; b.t = v[4];
        b.eop = 1'b0;
        b.kept = KEPT_W'(emit_count);
        b.empty = 1'b0;
        b.ovf = ovf_sticky;
        return b;
    endfunction

    // Walks one edge: keep the start when on or above the plane, then add
    // the crossing point when the edge strictly changes side.
    task automatic clip_edge(input coord_t a [VTX_N], input longint da,
                             input coord_t b [VTX_N], input longint db,
                             inout int produced);
        coord_t  mid [VTX_N];
        longint  num, den, frac, diff;
        if (da >= 0)
        begin
            expected_beats.push_back(make_beat(a));
            produced++;
        end
        if (da == 0 || db == 0 || ((da > 0) == (db > 0)))
            return;
        num = (da < 0) ? -da : da;
        den = num + ((db < 0) ? -db : db);
        // The numerator fits 48+24 bits only as unsigned 128-bit math.
        frac = longint'((128'(num) << 24) / 128'(den));
        for (int i = 0; i < VTX_N; i++)
        begin
            diff = longint'(b[i]) - longint'(a[i]);
            mid[i] = coord_t'(longint'(a[i]) + floor_shr(frac * diff + (64'sd1 <<< 23), 24));
        end
        expected_beats.push_back(make_beat(mid));
        produced++;
    endtask

    task automatic predict_vertex(input coord_t v [VTX_N], input bit last);
        longint d;
        int     produced;
        clip_beat_t e;
        produced = 0;
        d = longint'(pl_nx) * longint'(v[0]) + longint'(pl_ny) * longint'(v[1])
          + longint'(pl_nz) * longint'(v[2]);
        d = floor_shr(d, 16) - longint'(pl_d);
        if (have_vertex)
            clip_edge(prev_v, prev_dist, v, d, produced);
        else
        begin
            first_v = v;
            first_dist = d;
            have_vertex = 1'b1;
        end
        prev_v = v;
        prev_dist = d;
        if (last)
        begin
            clip_edge(v, d, first_v, first_dist, produced);
            if (produced == 0)
            begin
                e = '{default: '0};
                e.eop = 1'b1;
                e.empty = 1'b1;
                expected_beats.push_back(e);
            end
            else
                expected_beats[$].eop = 1'b1;
            have_vertex = 1'b0;
            emit_count = 0;
            ovf_sticky = 1'b0;
        end
    endtask

    // Register writes only happen while the block has nothing in flight.
    task automatic write_plane(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_NORMAL_X: pl_nx = val[NRM_W-1:0];
            REG_NORMAL_Y: pl_ny = val[NRM_W-1:0];
            REG_NORMAL_Z: pl_nz = val[NRM_W-1:0];
            REG_PLANE_DISTANCE: pl_d = val[PD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_plane(input int nx, input int ny, input int nz, input int pd);
        write_plane(REG_NORMAL_X, CFG_W'(nx));
        write_plane(REG_NORMAL_Y, CFG_W'(ny));
        write_plane(REG_NORMAL_Z, CFG_W'(nz));
        write_plane(REG_PLANE_DISTANCE, CFG_W'(pd));
    endtask

    // Sends one vertex beat, with a random gap ahead of it when idling is on.
    task automatic send_vertex(input coord_t v [VTX_N], input bit last);
        @(negedge clk);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            @(negedge clk);
        vtx_ch.valid = 1'b1;
        vtx_ch.pos_x = v[0];
        vtx_ch.pos_y = v[1];
        vtx_ch.pos_z = v[2];
        vtx_ch.tex_s = v[3];
        vtx_ch.tex_t = v[4];
        vtx_ch.final_vertex = last;
        @(posedge clk);
        while (!vtx_ch.ready)
            @(posedge clk);
        predict_vertex(v, last);
        vertices_sent++;
        if (last)
            polygons_sent++;
        @(negedge clk);
        vtx_ch.valid = 1'b0;
    endtask

    // Waits until every expected beat came back, then lets the block settle
    // for longer than its worst per-vertex latency.
    task automatic drain_all();
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic coord_t rand_coord(int mode);
        case (mode)
            0: return coord_t'($urandom());
            1: return coord_t'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
            default: return coord_t'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    task automatic send_polygon(input int nverts, input int mode);
        coord_t v [VTX_N];
        for (int k = 0; k < nverts; k++)
        begin
            for (int i = 0; i < VTX_N; i++)
                v[i] = rand_coord(mode);
            send_vertex(v, k == nverts - 1);
        end
    endtask

    // Compares each accepted result beat with the oldest expectation.
    always @(posedge clk)
    begin
        clip_beat_t e;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_beats.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("Unexpected result beat at cycle %0d", cycle_count);
            end
            else
            begin
                e = expected_beats.pop_front();
                beats_checked++;
                if (res_ch.out_x !== e.x || res_ch.out_y !== e.y || res_ch.out_z !== e.z
                    || res_ch.out_s !== e.s || res_ch.out_t !== e.t
                    || res_ch.end_of_polygon !== e.eop || res_ch.kept_count !== e.kept
                    || res_ch.nothing_kept !== e.empty || res_ch.count_overflow !== e.ovf)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("Mismatch at beat %0d:", beats_checked);
                        $display("  exp xyzst %h %h %h %h %h eop %b kept %0d empty %b ovf %b",
                                 e.x, e.y, e.z, e.s, e.t, e.eop, e.kept, e.empty, e.ovf);
                        $display("  got xyzst %h %h %h %h %h eop %b kept %0d empty %b ovf %b",
                                 res_ch.out_x, res_ch.out_y, res_ch.out_z, res_ch.out_s,
                                 res_ch.out_t, res_ch.end_of_polygon, res_ch.kept_count,
                                 res_ch.nothing_kept, res_ch.count_overflow);
                    end
                end
            end
        end
    end

    // Receiver stalls are drawn once per cycle on the falling edge.
    always @(negedge clk)
    begin
        res_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    // Extreme field values, the reset plane, and these special cases:
    // single vertex, fully clipped, vertex on the plane, a crossing edge.
    task automatic test_directed();
        coord_t v [VTX_N];
        // Reset plane is z >= 0. A one-vertex polygon kept, then one dropped.
        v = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh00010000, 32'sh7FFFFFFF, 32'sh80000000};
        send_vertex(v, 1'b1);
        v = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF};
        send_vertex(v, 1'b1);
        // Triangle crossing the plane with extreme texture values.
        v = '{32'sh7FFFFFFF, 0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF};
        send_vertex(v, 1'b0);
        v = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000};
        send_vertex(v, 1'b0);
        v = '{0, 32'sh80000000, 0, 0, 0};
        send_vertex(v, 1'b1);
        // Quad fully below the plane.
        for (int k = 0; k < 4; k++)
        begin
            v = '{coord_t'(k), coord_t'(-k), -32'sh10000 - coord_t'(k), 5, 6};
            send_vertex(v, k == 3);
        end
        drain_all();
        // Extreme normals and offsets.
        set_plane(-65536, 65536, -65536, 32'sh7FFFFFFF);
        send_polygon(3, 0);
        drain_all();
        set_plane(32'h1FFFF, 32'h20000, 0, 32'sh80000000);
        send_polygon(3, 0);
        drain_all();
        set_plane(0, 0, 65536, 0);
    endtask

    // A polygon larger than the count limit so kept_count saturates and the
    // overflow flag sets, then clears for the next polygon.
    task automatic test_count_overflow();
        coord_t v [VTX_N];
        for (int k = 0; k < MAX_VERTS + 3; k++)
        begin
            v = '{coord_t'(k), 0, 32'sh10000, coord_t'(k), 0};
            send_vertex(v, k == MAX_VERTS + 2);
        end
        send_polygon(3, 2);
        drain_all();
    endtask

    // Random polygons of one to six vertices under the current plane setting.
    task automatic test_random(input int npolys);
        int mode;
        for (int p = 0; p < npolys; p++)
        begin
            mode = $urandom_range(2);
            send_polygon($urandom_range(1, 6), mode);
            // Hold-off: wait out every pending result now and then.
            if ($urandom_range(9) == 0)
                while (expected_beats.size() != 0)
                    @(posedge clk);
        end
        drain_all();
    endtask

    task automatic test_idle_phases();
        set_plane(65536, 0, 0, 0);
        send_idle_pct = 0;  recv_stall_pct = 0;
        test_random(12);
        set_plane($urandom_range(0, 131072) - 65536, $urandom_range(0, 131072) - 65536,
                  $urandom_range(0, 131072) - 65536, $urandom_range(0, 40000) - 20000);
        send_idle_pct = 85; recv_stall_pct = 0;
        test_random(12);
        set_plane(0, -65536, 32768, -65536);
        send_idle_pct = 0;  recv_stall_pct = 85;
        test_random(12);
        set_plane(int'($urandom()) , int'($urandom()), int'($urandom()), int'($urandom()));
        send_idle_pct = 34; recv_stall_pct = 34;
        test_random(12);
        send_idle_pct = 0;  recv_stall_pct = 0;
    endtask

    initial
    begin
        cycle_count = 0;
        error_count = 0;
        beats_checked = 0;
        vertices_sent = 0;
        polygons_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        pl_nx = 0; pl_ny = 0; pl_nz = NORMAL_Z_RESET; pl_d = 0;
        have_vertex = 1'b0; emit_count = 0; ovf_sticky = 1'b0;
        first_dist = 0; prev_dist = 0;
        for (int i = 0; i < VTX_N; i++)
        begin
            first_v[i] = 0;
            prev_v[i] = 0;
        end
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        vtx_ch.valid = 1'b0;
        vtx_ch.pos_x = 0; vtx_ch.pos_y = 0; vtx_ch.pos_z = 0;
        vtx_ch.tex_s = 0; vtx_ch.tex_t = 0; vtx_ch.final_vertex = 1'b0;
        res_ch.ready = 1'b0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_count_overflow();
        test_idle_phases();

        drain_all();
        $display("Covered %0d vertices in %0d polygons, %0d result beats checked,",
                 vertices_sent, polygons_sent, beats_checked);
        $display("under several plane settings and four idle/stall mixes.");
        if (error_count == 0 && expected_beats.size() == 0)
            $display("Regression PASS");
        else
        begin
            $display("%0d mismatches, %0d beats still expected", error_count,
                     expected_beats.size());
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

`default_nettype wire
